// File: rtl/core/assert_macros.svh
// assertion helpers used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold whenever antecedent holds
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// condition must never be seen outside reset
`define ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed");

`endif

// File: rtl/core/prrs_pkg.sv
package prrs_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int FIFO_DEPTH = 2;
  localparam int FW = $clog2(FIFO_DEPTH);
  localparam int FCW = $clog2(FIFO_DEPTH + 1);

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_SERVE = 1'b1;

  localparam logic [1:0] CLASS_FIRST = 2'd0;
  localparam logic [1:0] CLASS_LAST  = 2'd2;

  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_REQUEUED  = 3'd2;
  localparam logic [2:0] ST_COMPLETED = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  typedef struct packed {
    logic [7:0]  id;
    logic [1:0]  cls;
    logic [15:0] time_left;
  } job_t;

  localparam int JOB_W = $bits(job_t);

  typedef struct packed {
    logic op;
    job_t job;
  } item_t;

  typedef struct packed {
    logic [CW-1:0] ring_cnt;
    logic [CW-1:0] pend_total;
  } bk_stat_t;

endpackage

// File: rtl/core/prrs_ram.sv
module prrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/prrs_front.sv
module prrs_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 op,
  input  logic [7:0]           job_id,
  input  logic [1:0]           job_class,
  input  logic [15:0]          job_time,
  output logic                 item_valid,
  output prrs_pkg::item_t      item,
  input  logic                 item_pop
);

  prrs_pkg::item_t q [prrs_pkg::FIFO_DEPTH];
  logic [prrs_pkg::FW-1:0]  wptr;
  logic [prrs_pkg::FW-1:0]  rptr;
  logic [prrs_pkg::FCW-1:0] cnt;
  prrs_pkg::item_t          in_item;
  logic                     push;
  logic                     pop;

  // class 3 is folded into the last class on the way in
  always_comb begin
    in_item.op            = op;
    in_item.job.id        = job_id;
    in_item.job.cls       = (job_class > prrs_pkg::CLASS_LAST) ? prrs_pkg::CLASS_LAST
                                                               : job_class;
    in_item.job.time_left = job_time;
  end

  assign in_stall   = (cnt == prrs_pkg::FCW'(prrs_pkg::FIFO_DEPTH));
  assign push       = in_valid && !in_stall;
  assign item_valid = (cnt != '0);
  assign item       = q[rptr];
  assign pop        = item_pop && item_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= in_item;
    end
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == prrs_pkg::FW'(prrs_pkg::FIFO_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == prrs_pkg::FW'(prrs_pkg::FIFO_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      cnt <= cnt + prrs_pkg::FCW'(push) - prrs_pkg::FCW'(pop);
    end
  end

endmodule

// File: rtl/core/prrs_back.sv
module prrs_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [15:0]           quantum,
  input  logic                  item_valid,
  input  prrs_pkg::item_t       item,
  output logic                  item_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            status,
  output logic [7:0]            served_id,
  output logic [1:0]            served_class,
  output logic [15:0]           time_before,
  output logic [15:0]           time_after,
  output prrs_pkg::bk_stat_t    stat
);

  typedef enum logic [2:0] {S_IDLE, S_MV_RD, S_MV_WR, S_RD, S_EX} state_t;

  state_t                    state;
  logic [prrs_pkg::AW-1:0]   head;
  logic [prrs_pkg::CW-1:0]   ring_cnt;
  logic [prrs_pkg::CW-1:0]   pcnt [3];
  logic [1:0]                mv_cls;
  logic [prrs_pkg::AW-1:0]   mv_idx;
  logic [prrs_pkg::CW-1:0]   mv_n;
  logic [prrs_pkg::CW-1:0]   mv_total;

  logic [prrs_pkg::CW-1:0]   total;
  logic                      out_free;
  logic                      take;
  logic                      mv_hit;
  logic                      mv_last;
  logic [prrs_pkg::CW:0]     tail_sum;
  logic [prrs_pkg::AW-1:0]   tail;
  logic                      requeue;
  logic [15:0]               time_rest;

  logic                      p_we;
  logic [prrs_pkg::AW-1:0]   p_waddr;
  prrs_pkg::job_t            p_rdata;
  logic                      r_we;
  logic [prrs_pkg::AW-1:0]   r_waddr;
  prrs_pkg::job_t            r_wdata;
  logic [prrs_pkg::AW-1:0]   r_raddr;
  prrs_pkg::job_t            r_rdata;

  assign total    = pcnt[0] + pcnt[1] + pcnt[2];
  assign out_free = !out_valid || !out_stall;
  assign take     = (state == S_IDLE) && item_valid && out_free;
  assign item_pop = take;

  assign mv_hit  = (p_rdata.cls == mv_cls);
  assign mv_last = (prrs_pkg::CW'(mv_idx) == mv_total - prrs_pkg::CW'(1));

  // tail slot after the head leaves: head + old count, wrapped
  assign tail_sum  = (prrs_pkg::CW + 1)'(head) + (prrs_pkg::CW + 1)'(ring_cnt);
  assign tail      = (tail_sum >= (prrs_pkg::CW + 1)'(prrs_pkg::QUEUE_DEPTH))
                     ? prrs_pkg::AW'(tail_sum - (prrs_pkg::CW + 1)'(prrs_pkg::QUEUE_DEPTH))
                     : prrs_pkg::AW'(tail_sum);
  assign requeue   = (r_rdata.time_left > quantum);
  assign time_rest = r_rdata.time_left - quantum;

  assign p_we    = take && (item.op == prrs_pkg::OP_ADD)
                   && (total < prrs_pkg::CW'(prrs_pkg::QUEUE_DEPTH));
  assign p_waddr = prrs_pkg::AW'(total);

  always_comb begin
    r_we    = 1'b0;
    r_waddr = prrs_pkg::AW'(mv_n);
    r_wdata = p_rdata;
    if (state == S_MV_WR) begin
      r_we = mv_hit;
    end else if (state == S_EX) begin
      r_we                = requeue;
      r_waddr             = tail;
      r_wdata             = r_rdata;
      r_wdata.time_left   = time_rest;
    end
  end

  assign r_raddr = head;

  prrs_ram #(.WIDTH(prrs_pkg::JOB_W), .DEPTH(prrs_pkg::QUEUE_DEPTH)) u_pend_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (item.job),
    .raddr (mv_idx),
    .rdata (p_rdata)
  );

  prrs_ram #(.WIDTH(prrs_pkg::JOB_W), .DEPTH(prrs_pkg::QUEUE_DEPTH)) u_ring_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (r_waddr),
    .wdata (r_wdata),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  assign stat.ring_cnt   = ring_cnt;
  assign stat.pend_total = total;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      ring_cnt  <= '0;
      pcnt[0]   <= '0;
      pcnt[1]   <= '0;
      pcnt[2]   <= '0;
      out_valid <= 1'b0;
      mv_cls    <= prrs_pkg::CLASS_FIRST;
      mv_idx    <= '0;
      mv_n      <= '0;
      mv_total  <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (take) begin
            if (item.op == prrs_pkg::OP_ADD) begin
              out_valid    <= 1'b1;
              served_id    <= '0;
              served_class <= '0;
              time_before  <= '0;
              time_after   <= '0;
              if (p_we) begin
                status             <= prrs_pkg::ST_ADDED;
                pcnt[item.job.cls] <= pcnt[item.job.cls] + 1'b1;
              end else begin
                status <= prrs_pkg::ST_FULL;
              end
            end else if (ring_cnt != '0) begin
              state <= S_RD;
            end else if (total == '0) begin
              out_valid    <= 1'b1;
              status       <= prrs_pkg::ST_EMPTY;
              served_id    <= '0;
              served_class <= '0;
              time_before  <= '0;
              time_after   <= '0;
            end else begin
              mv_cls   <= prrs_pkg::CLASS_FIRST;
              mv_idx   <= '0;
              mv_n     <= '0;
              mv_total <= total;
              state    <= S_MV_RD;
            end
          end
        end
        S_MV_RD: begin
          state <= S_MV_WR;
        end
        S_MV_WR: begin
          if (mv_hit) begin
            mv_n <= mv_n + 1'b1;
          end
          mv_idx <= mv_idx + 1'b1;
          state  <= S_MV_RD;
          if (mv_last) begin
            mv_idx <= '0;
            if (mv_cls == prrs_pkg::CLASS_LAST) begin
              // one pass per class done, ring now holds every pending job
              head     <= '0;
              ring_cnt <= mv_n + prrs_pkg::CW'(mv_hit);
              pcnt[0]  <= '0;
              pcnt[1]  <= '0;
              pcnt[2]  <= '0;
              state    <= S_RD;
            end else begin
              mv_cls <= mv_cls + 1'b1;
            end
          end
        end
        S_RD: begin
          state <= S_EX;
        end
        S_EX: begin
          head <= (head == prrs_pkg::AW'(prrs_pkg::QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
          if (!requeue) begin
            ring_cnt <= ring_cnt - 1'b1;
          end
          out_valid    <= 1'b1;
          status       <= requeue ? prrs_pkg::ST_REQUEUED : prrs_pkg::ST_COMPLETED;
          served_id    <= r_rdata.id;
          served_class <= r_rdata.cls;
          time_before  <= r_rdata.time_left;
          time_after   <= requeue ? time_rest : 16'd0;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/priority_round_robin_scheduler_top.sv
// channel   | handshake                     | payload
// ----------+-------------------------------+---------------------------------------------
// input     | in_valid / in_stall           | op, job_id, job_class, job_time
// output    | out_valid / out_stall         | status, served_id, served_class,
//           |                               | time_before, time_after
// config    | psel, penable, pwrite, pready | paddr, pwdata, prdata (quantum at 0x0)
//
// add: answered from the idle state of the back end; serve with jobs in the ring: S_RD (ring ram read), then S_EX.
// serve on an empty ring first copies the pending store, one pass per class, each entry read
// in S_MV_RD and written in S_MV_WR, as the pending ram has a single read port.
// a two-entry input queue keeps taking transactions while the back end works, until it is full.
// the output register holds a result until taken; the back end waits meanwhile.
// rst is synchronous; ram contents are not cleared, counts and pointers are.
`include "assert_macros.svh"

module priority_round_robin_scheduler_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [7:0]  job_id,
  input  logic [1:0]  job_class,
  input  logic [15:0] job_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [7:0]  served_id,
  output logic [1:0]  served_class,
  output logic [15:0] time_before,
  output logic [15:0] time_after
);

  localparam logic REG_QUANTUM = 1'b0;

  logic [15:0]          quantum;
  logic                 item_valid;
  prrs_pkg::item_t      item;
  logic                 item_pop;
  prrs_pkg::bk_stat_t   stat;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_QUANTUM) ? {16'd0, quantum} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= 16'd3;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_QUANTUM) begin
      quantum <= pwdata[15:0];
    end
  end

  prrs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .job_id     (job_id),
    .job_class  (job_class),
    .job_time   (job_time),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  prrs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .quantum      (quantum),
    .item_valid   (item_valid),
    .item         (item),
    .item_pop     (item_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .served_id    (served_id),
    .served_class (served_class),
    .time_before  (time_before),
    .time_after   (time_after),
    .stat         (stat)
  );

  `ASSERT_NEVER(a_pend_bound, stat.pend_total > prrs_pkg::CW'(prrs_pkg::QUEUE_DEPTH))
  `ASSERT_NEVER(a_ring_bound, stat.ring_cnt > prrs_pkg::CW'(prrs_pkg::QUEUE_DEPTH))
  `ASSERT_IMPLIES(a_pop_free, item_pop, item_valid && (!out_valid || !out_stall))

endmodule
